[rtl/c39bwd_pkg.sv]
// shared constants, types and the symbol pattern table of the code 39 bar width decoder
package c39bwd_pkg;

   localparam int TIME_BITS  = 32;
   localparam int NUM_BARS   = 9;
   localparam int NUM_SYMS   = 27;
   localparam int STAR_INDEX = 26;
   localparam int BAR_IDX_BITS = $clog2(NUM_BARS);
   localparam int SYM_IDX_BITS = $clog2(NUM_SYMS);
   localparam int PAT_BITS   = 4 * NUM_BARS;

   localparam logic [6:0] ASCII_A = 7'd65;

   // request command codes
   localparam logic CMD_SAMPLE  = 1'b0;
   localparam logic CMD_RESTART = 1'b1;

   typedef logic [TIME_BITS-1:0]    width_type;
   typedef logic [PAT_BITS-1:0]     pattern_type;
   typedef logic [SYM_IDX_BITS-1:0] sym_idx_type;

   // one hex nibble per bar, first bar in the top nibble
   localparam pattern_type PATTERN_TABLE [NUM_SYMS] = '{
      36'h031312130, 36'h130213130, 36'h030213131, 36'h131203130, 36'h031203131,
      36'h130203131, 36'h131213030, 36'h031213031, 36'h130213031, 36'h131203031,
      36'h031213120, 36'h130213120, 36'h030213121, 36'h131203120, 36'h031203121,
      36'h130203121, 36'h131213020, 36'h031213021, 36'h130213021, 36'h131203021,
      36'h021213130, 36'h120213130, 36'h020213131, 36'h121203130, 36'h021203131,
      36'h120303131, 36'h121303031
   };

endpackage

[rtl/code39_bar_width_decoder.sv]
// code 39 bar width decoder: bar collection, rank selection, threshold and table match
//
//  channel | ports                                  | direction
//  --------+----------------------------------------+----------
//  req     | req_valid/req_ready, cmd level time_us  | in
//  rsp     | rsp_valid/rsp_ready, seven result fields| out
//
// a word that does not complete a character is answered in the cycle after it is taken.
// the word that ends the ninth bar starts a decode: the rank unit (one bar against all
// nine per cycle), threshold, digits, forward match, reverse match when the forward
// match fails, then the result write.
// req_ready is low while a decode runs or the result register is still full.
// reset is synchronous and clears the collector, the framing state and rsp_valid.
module code39_bar_width_decoder (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic                           req_cmd,
   input  logic                           req_level,
   input  logic [31:0]                    req_time_us,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic                           rsp_char_done,
   output logic                           rsp_match_found,
   output logic [4:0]                     rsp_char_index,
   output logic                           rsp_reversed_match,
   output logic                           rsp_data_valid,
   output logic [6:0]                     rsp_data_char,
   output logic                           rsp_in_frame
);
   import c39bwd_pkg::*;

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_RANK   = 3'd1;
   localparam logic [2:0] ST_THRESH = 3'd2;
   localparam logic [2:0] ST_DIGITS = 3'd3;
   localparam logic [2:0] ST_FWD    = 3'd4;
   localparam logic [2:0] ST_REV    = 3'd5;
   localparam logic [2:0] ST_FINISH = 3'd6;

   logic [2:0]              state_ff, state_in;
   logic                    level_known_ff, level_known_in;
   logic                    prev_level_ff, prev_level_in;
   width_type               edge_time_ff, edge_time_in;
   logic [BAR_IDX_BITS-1:0] bar_count_ff, bar_count_in;
   logic                    bar_color_ff [NUM_BARS];
   width_type               bar_width_ff [NUM_BARS];
   logic                    framed_ff, framed_in;

   logic [BAR_IDX_BITS-1:0] rank_idx_ff, rank_idx_in;
   width_type               sel_a_ff, sel_a_in;
   width_type               sel_b_ff, sel_b_in;
   width_type               thr_ff, thr_in;
   pattern_type             fwd_pat_ff, fwd_pat_in;
   pattern_type             rev_pat_ff, rev_pat_in;
   logic                    found_ff, found_in;
   logic                    rev_hit_ff, rev_hit_in;
   sym_idx_type             sym_ff, sym_in;

   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    char_done_ff, char_done_in;
   logic                    match_found_ff, match_found_in;
   logic [4:0]              char_index_ff, char_index_in;
   logic                    reversed_ff, reversed_in;
   logic                    data_valid_ff, data_valid_in;
   logic [6:0]              data_char_ff, data_char_in;
   logic                    in_frame_ff, in_frame_in;

   logic                    accept;
   logic                    slot_free;
   logic                    bar_wr;
   width_type               new_width;
   logic [BAR_IDX_BITS:0]   rank_cnt;
   width_type               cur_width;
   logic                    match_hit;
   sym_idx_type             match_sym;
   pattern_type             match_pat;

   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE) && slot_free;
   assign accept    = req_valid && req_ready;
   assign new_width = req_time_us - edge_time_ff;
   assign bar_wr    = accept && (req_cmd == CMD_SAMPLE) && level_known_ff &&
                      (req_level != prev_level_ff);
   assign cur_width = bar_width_ff[rank_idx_ff];

   // stable rank of the current bar among all nine
   always_comb begin
      rank_cnt = '0;
      for (int j = 0; j < NUM_BARS; j++) begin
         if ((bar_width_ff[j] < cur_width) ||
             ((bar_width_ff[j] == cur_width) && (BAR_IDX_BITS'(j) < rank_idx_ff))) begin
            rank_cnt = rank_cnt + (BAR_IDX_BITS+1)'(1);
         end
      end
   end

   // first table entry equal to the pattern under test
   always_comb begin
      match_pat = (state_ff == ST_REV) ? rev_pat_ff : fwd_pat_ff;
      match_hit = 1'b0;
      match_sym = '0;
      for (int s = NUM_SYMS - 1; s >= 0; s--) begin
         if (PATTERN_TABLE[s] == match_pat) begin
            match_hit = 1'b1;
            match_sym = SYM_IDX_BITS'(s);
         end
      end
   end

   always_comb begin
      state_in       = state_ff;
      level_known_in = level_known_ff;
      prev_level_in  = prev_level_ff;
      edge_time_in   = edge_time_ff;
      bar_count_in   = bar_count_ff;
      framed_in      = framed_ff;
      rank_idx_in    = rank_idx_ff;
      sel_a_in       = sel_a_ff;
      sel_b_in       = sel_b_ff;
      thr_in         = thr_ff;
      fwd_pat_in     = fwd_pat_ff;
      rev_pat_in     = rev_pat_ff;
      found_in       = found_ff;
      rev_hit_in     = rev_hit_ff;
      sym_in         = sym_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      char_done_in   = char_done_ff;
      match_found_in = match_found_ff;
      char_index_in  = char_index_ff;
      reversed_in    = reversed_ff;
      data_valid_in  = data_valid_ff;
      data_char_in   = data_char_ff;
      in_frame_in    = in_frame_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_cmd == CMD_RESTART) begin
                  framed_in      = 1'b0;
                  level_known_in = 1'b0;
                  prev_level_in  = 1'b0;
                  edge_time_in   = '0;
                  bar_count_in   = '0;
               end else if (!level_known_ff) begin
                  level_known_in = 1'b1;
                  prev_level_in  = req_level;
                  edge_time_in   = req_time_us;
               end else if (req_level != prev_level_ff) begin
                  prev_level_in = req_level;
                  edge_time_in  = req_time_us;
                  bar_count_in  = bar_count_ff + BAR_IDX_BITS'(1);
               end
               if (bar_wr && (bar_count_ff == BAR_IDX_BITS'(NUM_BARS - 1))) begin
                  // ninth bar: restart the collector and decode
                  level_known_in = 1'b0;
                  prev_level_in  = 1'b0;
                  edge_time_in   = '0;
                  bar_count_in   = '0;
                  rank_idx_in    = '0;
                  state_in       = ST_RANK;
               end else begin
                  rsp_valid_in   = 1'b1;
                  char_done_in   = 1'b0;
                  match_found_in = 1'b0;
                  char_index_in  = '0;
                  reversed_in    = 1'b0;
                  data_valid_in  = 1'b0;
                  data_char_in   = '0;
                  in_frame_in    = (req_cmd == CMD_RESTART) ? 1'b0 : framed_ff;
               end
            end
         end
         ST_RANK: begin
            if (rank_cnt == (BAR_IDX_BITS+1)'(5)) sel_a_in = cur_width;
            if (rank_cnt == (BAR_IDX_BITS+1)'(6)) sel_b_in = cur_width;
            rank_idx_in = rank_idx_ff + BAR_IDX_BITS'(1);
            if (rank_idx_ff == BAR_IDX_BITS'(NUM_BARS - 1)) state_in = ST_THRESH;
         end
         ST_THRESH: begin
            thr_in   = (sel_a_ff >> 1) + (sel_b_ff >> 1) +
                       {{(TIME_BITS-1){1'b0}}, sel_a_ff[0] & sel_b_ff[0]};
            state_in = ST_DIGITS;
         end
         ST_DIGITS: begin
            // black narrow 1, black wide 0, white narrow 3, white wide 2
            for (int k = 0; k < NUM_BARS; k++) begin
               fwd_pat_in[(NUM_BARS-1-k)*4 +: 4] =
                  {2'b00, !bar_color_ff[k], bar_width_ff[k] < thr_ff};
               rev_pat_in[k*4 +: 4] =
                  {2'b00, !bar_color_ff[k], bar_width_ff[k] < thr_ff};
            end
            state_in = ST_FWD;
         end
         ST_FWD: begin
            found_in   = match_hit;
            rev_hit_in = 1'b0;
            sym_in     = match_sym;
            state_in   = match_hit ? ST_FINISH : ST_REV;
         end
         ST_REV: begin
            found_in   = match_hit;
            rev_hit_in = match_hit;
            sym_in     = match_sym;
            state_in   = ST_FINISH;
         end
         ST_FINISH: begin
            if (slot_free) begin
               rsp_valid_in   = 1'b1;
               char_done_in   = 1'b1;
               match_found_in = found_ff;
               char_index_in  = found_ff ? 5'(sym_ff) : 5'd0;
               reversed_in    = rev_hit_ff;
               data_valid_in  = 1'b0;
               data_char_in   = '0;
               if (found_ff && (sym_ff == SYM_IDX_BITS'(STAR_INDEX))) begin
                  framed_in = !framed_ff;
               end else if (found_ff && framed_ff) begin
                  data_valid_in = 1'b1;
                  data_char_in  = ASCII_A + 7'(sym_ff);
               end
               in_frame_in = (found_ff && (sym_ff == SYM_IDX_BITS'(STAR_INDEX))) ?
                             !framed_ff : framed_ff;
               state_in    = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         level_known_ff <= 1'b0;
         prev_level_ff  <= 1'b0;
         edge_time_ff   <= '0;
         bar_count_ff   <= '0;
         framed_ff      <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         level_known_ff <= level_known_in;
         prev_level_ff  <= prev_level_in;
         edge_time_ff   <= edge_time_in;
         bar_count_ff   <= bar_count_in;
         framed_ff      <= framed_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // bar store, written one word at a time
   always_ff @(posedge clock) begin
      if (bar_wr) begin
         bar_color_ff[bar_count_ff] <= prev_level_ff;
         bar_width_ff[bar_count_ff] <= new_width;
      end
   end

   always_ff @(posedge clock) begin
      rank_idx_ff    <= rank_idx_in;
      sel_a_ff       <= sel_a_in;
      sel_b_ff       <= sel_b_in;
      thr_ff         <= thr_in;
      fwd_pat_ff     <= fwd_pat_in;
      rev_pat_ff     <= rev_pat_in;
      found_ff       <= found_in;
      rev_hit_ff     <= rev_hit_in;
      sym_ff         <= sym_in;
      char_done_ff   <= char_done_in;
      match_found_ff <= match_found_in;
      char_index_ff  <= char_index_in;
      reversed_ff    <= reversed_in;
      data_valid_ff  <= data_valid_in;
      data_char_ff   <= data_char_in;
      in_frame_ff    <= in_frame_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_char_done      = char_done_ff;
   assign rsp_match_found    = match_found_ff;
   assign rsp_char_index     = char_index_ff;
   assign rsp_reversed_match = reversed_ff;
   assign rsp_data_valid     = data_valid_ff;
   assign rsp_data_char      = data_char_ff;
   assign rsp_in_frame       = in_frame_ff;

endmodule

[tb/c39bwd_checker.sv]
// scoreboard for the code 39 bar width decoder: predicts every result word and compares it
module c39bwd_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic        req_cmd,
   input  logic        req_level,
   input  logic [31:0] req_time_us,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic        rsp_char_done,
   input  logic        rsp_match_found,
   input  logic [4:0]  rsp_char_index,
   input  logic        rsp_reversed_match,
   input  logic        rsp_data_valid,
   input  logic [6:0]  rsp_data_char,
   input  logic        rsp_in_frame,
   output int          fail_count,
   output int          pending_words
);
   timeunit 1ns;
   timeprecision 1ps;
   import c39bwd_pkg::*;

   typedef struct packed {
      logic       char_done;
      logic       match_found;
      logic [4:0] char_index;
      logic       reversed_match;
      logic       data_valid;
      logic [6:0] data_char;
      logic       in_frame;
   } scan_result_type;

   // first bar in the top nibble; A..Z then the asterisk
   localparam logic [35:0] SYMBOL_DIGITS [NUM_SYMS] = '{
      36'h031312130, 36'h130213130, 36'h030213131, 36'h131203130, 36'h031203131,
      36'h130203131, 36'h131213030, 36'h031213031, 36'h130213031, 36'h131203031,
      36'h031213120, 36'h130213120, 36'h030213121, 36'h131203120, 36'h031203121,
      36'h130203121, 36'h131213020, 36'h031213021, 36'h130213021, 36'h131203021,
      36'h021213130, 36'h120213130, 36'h020213131, 36'h121203130, 36'h021203131,
      36'h120303131, 36'h121303031
   };

   logic            level_seen;
   logic            last_level;
   width_type       last_edge;
   int              bars_held;
   logic            bar_black [NUM_BARS];
   width_type       bar_len [NUM_BARS];
   logic            frame_open;
   scan_result_type expected_q [$];
   int              mismatches;

   function automatic void clear_collector();
      level_seen = 1'b0;
      last_level = 1'b0;
      last_edge  = '0;
      bars_held  = 0;
      for (int i = 0; i < NUM_BARS; i++) begin
         bar_black[i] = 1'b0;
         bar_len[i]   = '0;
      end
   endfunction

   function automatic int lookup_symbol(input logic [1:0] digits [NUM_BARS], input bit rev);
      bit same;
      logic [1:0] d;
      for (int s = 0; s < NUM_SYMS; s++) begin
         same = 1'b1;
         for (int k = 0; k < NUM_BARS; k++) begin
            d = rev ? digits[NUM_BARS-1-k] : digits[k];
            if (SYMBOL_DIGITS[s][4*(NUM_BARS-1-k) +: 4] != {2'b00, d})
               same = 1'b0;
         end
         if (same)
            return s;
      end
      return -1;
   endfunction

   function automatic scan_result_type decode_bars();
      width_type       ranked [NUM_BARS];
      width_type       v, lo, hi, thr;
      logic [1:0]      digits [NUM_BARS];
      int              j, sym;
      bit              rev;
      scan_result_type r;
      r = '0;
      r.char_done = 1'b1;
      for (int i = 0; i < NUM_BARS; i++)
         ranked[i] = bar_len[i];
      for (int i = 1; i < NUM_BARS; i++) begin
         v = ranked[i];
         j = i;
         while (j > 0 && ranked[j-1] > v) begin
            ranked[j] = ranked[j-1];
            j--;
         end
         ranked[j] = v;
      end
      // floor mean of the 6th and 7th smallest, kept inside the width
      lo  = ranked[5];
      hi  = ranked[6];
      thr = (lo >> 1) + (hi >> 1) + width_type'(lo[0] & hi[0]);
      // digit is {white, narrow}
      for (int i = 0; i < NUM_BARS; i++)
         digits[i] = {~bar_black[i], bar_len[i] < thr};
      rev = 1'b0;
      sym = lookup_symbol(digits, 1'b0);
      if (sym < 0) begin
         sym = lookup_symbol(digits, 1'b1);
         rev = (sym >= 0);
      end
      if (sym >= 0) begin
         r.match_found    = 1'b1;
         r.char_index     = 5'(sym);
         r.reversed_match = rev;
         if (sym == STAR_INDEX) begin
            frame_open = ~frame_open;
         end else if (frame_open) begin
            r.data_valid = 1'b1;
            r.data_char  = ASCII_A + 7'(sym);
         end
      end
      return r;
   endfunction

   function automatic scan_result_type predict_word(input logic cmd, input logic lvl,
                                                    input width_type t);
      scan_result_type r;
      r = '0;
      if (cmd == CMD_RESTART) begin
         frame_open = 1'b0;
         clear_collector();
      end else if (!level_seen) begin
         level_seen = 1'b1;
         last_level = lvl;
         last_edge  = t;
      end else if (lvl != last_level) begin
         if (bars_held < NUM_BARS) begin
            bar_black[bars_held] = last_level;
            bar_len[bars_held]   = t - last_edge;
            bars_held++;
         end
         last_level = lvl;
         last_edge  = t;
         if (bars_held >= NUM_BARS) begin
            r = decode_bars();
            clear_collector();
         end
      end
      r.in_frame = frame_open;
      return r;
   endfunction

   function automatic int field_differs(input string name, input int unsigned want,
                                        input int unsigned got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         return 1;
      end
      return 0;
   endfunction

   always @(posedge clock) begin
      scan_result_type want;
      int              bad;
      if (reset) begin
         clear_collector();
         frame_open = 1'b0;
         expected_q.delete();
         mismatches = 0;
      end else begin
         // check the result first so a word accepted on the same edge cannot hide it
         if (rsp_valid && rsp_ready) begin
            if (expected_q.size() == 0) begin
               $error("result word with nothing expected");
               mismatches++;
            end else begin
               want = expected_q.pop_front();
               bad  = field_differs("char_done", want.char_done, rsp_char_done)
                    + field_differs("match_found", want.match_found, rsp_match_found)
                    + field_differs("char_index", want.char_index, rsp_char_index)
                    + field_differs("reversed_match", want.reversed_match,
                                    rsp_reversed_match)
                    + field_differs("data_valid", want.data_valid, rsp_data_valid)
                    + field_differs("data_char", want.data_char, rsp_data_char)
                    + field_differs("in_frame", want.in_frame, rsp_in_frame);
               if (bad != 0)
                  mismatches++;
            end
         end
         if (req_valid && req_ready)
            expected_q.push_back(predict_word(req_cmd, req_level, req_time_us));
      end
      pending_words <= expected_q.size();
      fail_count    <= mismatches;
   end

endmodule

[tb/tb_top.sv]
// testbench top for the code 39 bar width decoder: clock, reset, bar stimulus and verdict
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import c39bwd_pkg::*;

   localparam int   RANDOM_WORDS = 1200;
   localparam int   CYCLE_LIMIT  = 400000;
   localparam int   HOLD_CYCLES  = 300;
   localparam int   DRAIN_CYCLES = 40;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic        req_cmd = 1'b0;
   logic        req_level = 1'b0;
   logic [31:0] req_time_us = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic        rsp_char_done;
   logic        rsp_match_found;
   logic [4:0]  rsp_char_index;
   logic        rsp_reversed_match;
   logic        rsp_data_valid;
   logic [6:0]  rsp_data_char;
   logic        rsp_in_frame;
   int          fail_count;
   int          pending_words;

   int          send_idle_pct = 12;
   int          recv_idle_pct = 60;
   int          hold_requests = 0;
   int          holds_done = 0;
   int          hold_left = 0;
   int          cycle_count = 0;
   int          words_sent = 0;
   width_type   time_cursor;

   code39_bar_width_decoder dut (.*);

   c39bwd_checker scan_check (.*);

   always #5 clock = ~clock;

   // receiver: random stalls, plus one long hold-off on request
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else if (holds_done != hold_requests) begin
         holds_done = hold_requests;
         hold_left  = HOLD_CYCLES;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("code39_bar_width_decoder: mismatch");
         $finish;
      end
   end

   // presents one word and returns on the edge that takes it
   task automatic send_word(input logic cmd, input logic lvl, input logic [31:0] t);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_cmd     <= cmd;
      req_level   <= lvl;
      req_time_us <= t;
      do @(posedge clock); while (!req_ready);
      words_sent++;
   endtask

   // first sample, then nine level changes; nibble bit 1 marks white, bit 0 narrow
   task automatic send_pattern(input pattern_type pat, input bit rev, input int flip_bar,
                               input width_type nar_lo, input width_type nar_hi,
                               input width_type wide_lo, input width_type wide_hi,
                               input int chatter_pct);
      logic [3:0] digit;
      logic       lvl;
      logic       narrow;
      width_type  w;
      digit = rev ? pat[3:0] : pat[PAT_BITS-1 -: 4];
      lvl   = ~digit[1];
      send_word(CMD_SAMPLE, lvl, time_cursor);
      for (int k = 0; k < NUM_BARS; k++) begin
         digit  = rev ? pat[4*k +: 4] : pat[4*(NUM_BARS-1-k) +: 4];
         narrow = digit[0] ^ (k == flip_bar);
         w = narrow ? $urandom_range(nar_hi, nar_lo) : $urandom_range(wide_hi, wide_lo);
         // same level mid-bar changes nothing
         if ($urandom_range(99) < chatter_pct)
            send_word(CMD_SAMPLE, lvl, time_cursor + $urandom_range(w));
         time_cursor += w;
         lvl = ~lvl;
         send_word(CMD_SAMPLE, lvl, time_cursor);
      end
   endtask

   task automatic send_random_char(input int sym);
      width_type nl, nh, wl, wh;
      int        flip;
      if ($urandom_range(9) == 0) begin
         // huge widths near the top of the counter
         nl = $urandom_range(32'h4000_0000);
         nh = nl + $urandom_range(32'h2000_0000);
         wl = 32'hC000_0000 + $urandom_range(32'h2000_0000);
         wh = wl + $urandom_range(32'h1FFF_FFFF);
      end else begin
         nl = $urandom_range(40);
         nh = nl + $urandom_range(30);
         wl = nh + $urandom_range(40, 2);
         wh = wl + $urandom_range(60);
      end
      flip = ($urandom_range(99) < 10) ? $urandom_range(NUM_BARS-1) : -1;
      send_pattern(PATTERN_TABLE[sym], $urandom_range(99) < 15, flip, nl, nh, wl, wh, 5);
   endtask

   task automatic send_noise(input int count);
      logic [31:0] t;
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(1))
            t = $urandom;
         else
            t = time_cursor + $urandom_range(200);
         time_cursor = t;
         send_word(($urandom_range(9) == 0) ? CMD_RESTART : CMD_SAMPLE,
                   1'($urandom_range(1)), t);
      end
   endtask

   task automatic wait_for_results();
      @(negedge clock);
      req_valid <= 1'b0;
      wait (pending_words == 0);
      @(posedge clock);
   endtask

   initial begin
      int phase_end;
      int pick;
      time_cursor = $urandom;
      repeat (6) @(negedge clock);
      reset <= 1'b0;

      // directed: restart with ignored fields, asterisk at minimum widths just below the wrap,
      // repeated level, reversed Z inside the frame with the widest possible bars
      send_word(CMD_RESTART, 1'b1, 32'hFFFF_FFFF);
      time_cursor = 32'hFFFF_FFF8;
      send_pattern(PATTERN_TABLE[STAR_INDEX], 1'b0, -1, '0, '0, 32'd2, 32'd2, 0);
      send_word(CMD_SAMPLE, 1'b1, time_cursor);
      send_word(CMD_SAMPLE, 1'b1, time_cursor + 32'd7);
      send_pattern(PATTERN_TABLE[25], 1'b1, -1, 32'd1, 32'd1,
                   32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);

      for (int phase = 0; phase < 3; phase++) begin
         send_idle_pct = (phase == 0) ? 12 : (phase == 1) ? 60 : 0;
         recv_idle_pct = (phase == 0) ? 60 : (phase == 1) ? 12 : 0;
         if (phase == 2)
            hold_requests++;
         phase_end = words_sent + RANDOM_WORDS / 3;
         while (words_sent < phase_end) begin
            pick = $urandom_range(99);
            if (pick < 65) begin
               if ($urandom_range(1))
                  send_word(CMD_RESTART, 1'($urandom_range(1)), $urandom);
               send_random_char(STAR_INDEX);
               repeat ($urandom_range(6, 1))
                  send_random_char($urandom_range(STAR_INDEX - 1));
               send_random_char(STAR_INDEX);
            end else if (pick < 80) begin
               repeat ($urandom_range(3, 1))
                  send_random_char($urandom_range(STAR_INDEX));
            end else if (pick < 92) begin
               send_noise($urandom_range(12, 1));
               // realign the collector after noise
               send_word(CMD_RESTART, 1'($urandom_range(1)), $urandom);
            end else begin
               send_word(CMD_RESTART, 1'($urandom_range(1)), $urandom);
            end
         end
         if (phase == 1)
            wait_for_results();
      end

      wait_for_results();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0)
         $display("code39_bar_width_decoder: match");
      else
         $display("code39_bar_width_decoder: mismatch");
      $finish;
   end

endmodule
